>>> rtl/first_fit_heap_allocator_assert.svh
// assertion macros for the first-fit heap allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FFHA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ffha assertion failed");

// next-cycle implication, disabled during reset
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ffha assertion failed");

`endif

>>> rtl/ffha_pkg.sv
// types and constants shared by the first-fit heap allocator
package ffha_pkg;

  localparam int unsigned OFF_W     = 21;
  localparam int unsigned LIMIT_CAP = 1048576;

  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_REUSED  = 3'd1;
  localparam logic [2:0] ST_FREED   = 3'd2;
  localparam logic [2:0] ST_NO_ROOM = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [20:0] req_bytes;
    logic [31:0] addr;
  } in_t;

  typedef struct packed {
    logic [31:0] address;
    logic [2:0]  status;
  } out_t;

  // request broadcast to every cell
  typedef struct packed {
    logic             func;
    logic [20:0]      req_bytes;
    logic [31:0]      addr;
    logic [31:0]      base;
  } qry_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             done;
    logic [OFF_W-1:0] start;
  } tok_t;

  // append of a new descriptor, taken by the cell whose index equals the count
  typedef struct packed {
    logic             en;
    logic [OFF_W-1:0] start;
    logic [20:0]      size;
  } wr_t;

endpackage

>>> rtl/first_fit_heap_allocator.sv
// top level of the first-fit heap allocator
// Usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes one request per
//   transfer: func 0 allocates req_bytes, func 1 frees the block at addr.
//   out channel (out_valid_o/out_ready_i/out_data_o) returns exactly one
//   result per request: address and status.
//   Registers heap_base (0x0) and heap_limit (0x4) sit on the APB port;
//   write them only while no request is in flight.
// Timing:
//   a request walks a token through MAX_BLOCKS descriptor cells, one cell
//   per cycle, then commits, and its result is registered in the output
//   register; the next request is taken the cycle after commit.
//   One request is worked on at a time; a new one may be taken while the
//   previous result still waits in the output register.
// Reset:
//   the table is empty, heap_base is 0 and heap_limit is 1048576.
// Stall:
//   if the receiver holds out_ready_i low, a finished search waits before
//   commit until the output register is free; nothing is dropped.
module first_fit_heap_allocator #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned DESC_BYTES   = 12,
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ffha_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ffha_pkg::out_t  out_data_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import ffha_pkg::*;

  `include "first_fit_heap_allocator_assert.svh"

  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DONE   = 2'd2;

  logic [1:0]       state_q, state_d;
  in_t              req_q;
  logic             inject_q;
  logic             hit_q;
  logic [OFF_W-1:0] hit_start_q;
  logic [CNT_W-1:0] count_q;
  logic [OFF_W-1:0] heap_top_q;
  logic             out_valid_q;
  out_t             out_q;

  logic [31:0]      base;
  logic [20:0]      limit_reg;
  qry_t             qry;
  wr_t              wr;
  tok_t             tok [MAX_BLOCKS+1];

  logic             accept;
  logic             commit;
  logic [OFF_W-1:0] top_off;
  logic [OFF_W:0]   new_start;
  logic [OFF_W+1:0] end_sum;
  logic [OFF_W-1:0] limit_eff;
  logic             room;
  out_t             res;

  ffha_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .base_o  (base),
    .limit_o (limit_reg)
  );

  assign qry.func      = req_q.func;
  assign qry.req_bytes = req_q.req_bytes;
  assign qry.addr      = req_q.addr;
  assign qry.base      = base;

  assign tok[0].valid = inject_q;
  assign tok[0].done  = 1'b0;
  assign tok[0].start = '0;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    ffha_cell #(
      .INDEX (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .qry_i   (qry),
      .count_i (count_q),
      .wr_i    (wr),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1])
    );
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign commit     = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // append position and room check
  assign top_off   = (count_q == '0) ? OFF_W'(HEADER_BYTES) : heap_top_q;
  assign new_start = {1'b0, top_off} + (OFF_W + 1)'(DESC_BYTES);
  assign end_sum   = {1'b0, new_start} + (OFF_W + 2)'(req_q.req_bytes);
  assign limit_eff = (limit_reg > OFF_W'(LIMIT_CAP)) ? OFF_W'(LIMIT_CAP) : limit_reg;
  assign room      = (count_q < CNT_W'(MAX_BLOCKS)) &&
                     (end_sum <= (OFF_W + 2)'(limit_eff));

  always_comb begin
    wr.en    = 1'b0;
    wr.start = new_start[OFF_W-1:0];
    wr.size  = req_q.req_bytes;
    res      = '0;
    if (req_q.func == FUNC_ALLOC) begin
      if (hit_q) begin
        res.address = base + {11'b0, hit_start_q};
        res.status  = ST_REUSED;
      end else if (room) begin
        res.address = base + {11'b0, new_start[OFF_W-1:0]};
        res.status  = ST_NEW;
        wr.en       = commit;
      end else begin
        res.status  = ST_NO_ROOM;
      end
    end else begin
      res.status = hit_q ? ST_FREED : ST_UNKNOWN;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (accept) state_d = S_SEARCH;
      S_SEARCH: if (tok[MAX_BLOCKS].valid) state_d = S_DONE;
      S_DONE:   if (commit) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      inject_q    <= 1'b0;
      hit_q       <= 1'b0;
      count_q     <= '0;
      heap_top_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      inject_q <= accept;
      if ((state_q == S_SEARCH) && tok[MAX_BLOCKS].valid) begin
        hit_q <= tok[MAX_BLOCKS].done;
      end
      if (wr.en) begin
        count_q    <= count_q + CNT_W'(1);
        heap_top_q <= end_sum[OFF_W-1:0];
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
    if ((state_q == S_SEARCH) && tok[MAX_BLOCKS].valid) begin
      hit_start_q <= tok[MAX_BLOCKS].start;
    end
    if (commit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `FFHA_ASSERT_NOW(a_tok_only_in_search, clk_i, rst_ni,
                   tok[MAX_BLOCKS].valid, state_q == S_SEARCH)
  `FFHA_ASSERT_NOW(a_count_bounded, clk_i, rst_ni,
                   1'b1, count_q <= CNT_W'(MAX_BLOCKS))
  `FFHA_ASSERT_NOW(a_top_bounded, clk_i, rst_ni,
                   count_q != '0, heap_top_q <= OFF_W'(LIMIT_CAP))
  `FFHA_ASSERT_NEXT(a_append_counts, clk_i, rst_ni,
                    wr.en, count_q == $past(count_q) + CNT_W'(1))

endmodule

>>> rtl/ffha_cfg.sv
// configuration registers behind the APB-style port
module ffha_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] base_o,
  output logic [20:0] limit_o
);
  import ffha_pkg::*;

  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  logic [31:0] base_q;
  logic [20:0] limit_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      limit_q <= OFF_W'(LIMIT_CAP);
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_BASE:  base_q  <= pwdata;
        REG_LIMIT: limit_q <= pwdata[20:0];
        default:   base_q  <= base_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BASE:  prdata = base_q;
      REG_LIMIT: prdata = {11'b0, limit_q};
      default:   prdata = '0;
    endcase
  end

  assign base_o  = base_q;
  assign limit_o = limit_q;

endmodule

>>> rtl/ffha_cell.sv
// one descriptor cell of the search chain
module ffha_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ffha_pkg::qry_t        qry_i,
  input  logic [CNT_W-1:0]      count_i,
  input  ffha_pkg::wr_t         wr_i,
  input  ffha_pkg::tok_t        tok_i,
  output ffha_pkg::tok_t        tok_o
);
  import ffha_pkg::*;

  localparam logic [CNT_W-1:0] IDX      = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(INDEX + 1);

  logic [OFF_W-1:0] start_q;
  logic [20:0]      size_q;
  logic             free_q;
  tok_t             tok_q;

  logic        used;
  logic        not_last;
  logic [31:0] pay_addr;
  logic        match;
  logic        take;
  logic        wr_hit;

  assign used     = IDX < count_i;
  assign not_last = IDX_NEXT < count_i;
  assign pay_addr = qry_i.base + {11'b0, start_q};
  assign wr_hit   = wr_i.en && (count_i == IDX);

  always_comb begin
    if (qry_i.func == FUNC_ALLOC) begin
      match = not_last && free_q && (qry_i.req_bytes < size_q);
    end else begin
      match = used && (pay_addr == qry_i.addr);
    end
  end

  assign take = tok_i.valid && !tok_i.done && match;

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      start_q <= wr_i.start;
      size_q  <= wr_i.size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= 1'b0;
    end else if (wr_hit) begin
      free_q <= 1'b0;
    end else if (take) begin
      // alloc claims the block, free releases it
      free_q <= (qry_i.func == FUNC_FREE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q.valid <= tok_i.valid;
      tok_q.done  <= tok_i.done || take;
      tok_q.start <= take ? start_q : tok_i.start;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> sim/ffha_checker.sv
// result checker for the first-fit heap allocator: tracks the heap table and compares every result
module ffha_checker #(
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned DESC_BYTES   = 12,
  parameter int unsigned HEADER_BYTES = 4,
  parameter logic [2:0]  BASE_ADDR    = 3'd0,
  parameter logic [2:0]  LIMIT_ADDR   = 3'd4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  ffha_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  ffha_pkg::out_t out_data_i,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  input  logic           pready,
  output int             pending_o,
  output int             errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ffha_pkg::*;

  logic [31:0] heap_base_q;
  logic [20:0] heap_limit_q;
  logic [20:0] blk_start [MAX_BLOCKS];
  logic [20:0] blk_size  [MAX_BLOCKS];
  logic        blk_free  [MAX_BLOCKS];
  int          blk_count;
  logic [31:0] heap_top_q;

  out_t expected_q[$];
  out_t want;

  // applies one request to the table copy and returns the result it must produce
  function automatic out_t serve_request(input in_t rq);
    out_t        res;
    logic [31:0] cap;
    logic [31:0] top;
    logic [31:0] start;
    res.address = '0;
    if (rq.func == FUNC_FREE) begin
      res.status = ST_UNKNOWN;
      for (int n = 0; n < blk_count; n++) begin
        if (heap_base_q + 32'(blk_start[n]) == rq.addr) begin
          blk_free[n] = 1'b1;
          res.status  = ST_FREED;
          return res;
        end
      end
      return res;
    end
    // first fit skips the last block
    for (int n = 0; n + 1 < blk_count; n++) begin
      if (blk_free[n] && rq.req_bytes < blk_size[n]) begin
        blk_free[n] = 1'b0;
        res.address = heap_base_q + 32'(blk_start[n]);
        res.status  = ST_REUSED;
        return res;
      end
    end
    cap   = (heap_limit_q > LIMIT_CAP) ? 32'(LIMIT_CAP) : 32'(heap_limit_q);
    top   = (blk_count == 0) ? 32'(HEADER_BYTES) : heap_top_q;
    start = top + 32'(DESC_BYTES);
    if (blk_count >= MAX_BLOCKS || start + 32'(rq.req_bytes) > cap) begin
      res.status = ST_NO_ROOM;
      return res;
    end
    blk_start[blk_count] = start[20:0];
    blk_size[blk_count]  = rq.req_bytes;
    blk_free[blk_count]  = 1'b0;
    blk_count++;
    heap_top_q  = start + 32'(rq.req_bytes);
    res.address = heap_base_q + start;
    res.status  = ST_NEW;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q  = '0;
      heap_limit_q = 21'(LIMIT_CAP);
      for (int n = 0; n < MAX_BLOCKS; n++) blk_free[n] = 1'b0;
      blk_count  = 0;
      heap_top_q = '0;
      expected_q.delete();
      pending_o = 0;
      errors_o  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == BASE_ADDR) heap_base_q = pwdata;
        else if (paddr == LIMIT_ADDR) heap_limit_q = pwdata[20:0];
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(serve_request(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding: address %h status %0d",
                 out_data_i.address, out_data_i.status);
          errors_o++;
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.address !== want.address) begin
            $error("address: expected %h, got %h", want.address, out_data_i.address);
            errors_o++;
          end
          if (out_data_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_i.status);
            errors_o++;
          end
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

>>> sim/tb.sv
// testbench top for the first-fit heap allocator: stimulus, register setup and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffha_pkg::*;

  localparam int unsigned MAX_BLOCKS   = 64;
  localparam int unsigned DESC_BYTES   = 12;
  localparam int unsigned HEADER_BYTES = 4;
  localparam logic [2:0]  REG_HEAP_BASE  = 3'd0;
  localparam logic [2:0]  REG_HEAP_LIMIT = 3'd4;
  localparam int          PHASES       = 5;
  localparam int          PHASE_ITEMS  = 380;
  localparam logic [31:0] DIR_BASE     = 32'hFFFF_FFF0;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_t        out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int pending;
  int errors;
  int send_gap_pct;
  int recv_stall_pct;

  logic [31:0] cur_base;
  logic [31:0] phase_base;
  logic [31:0] phase_limit;
  logic [31:0] known_off[$];
  logic [20:0] known_len[$];
  in_t         issued_q[$];
  in_t         done_item;

  first_fit_heap_allocator #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .DESC_BYTES  (DESC_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  ffha_checker #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .DESC_BYTES  (DESC_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .BASE_ADDR   (REG_HEAP_BASE),
    .LIMIT_ADDR  (REG_HEAP_LIMIT)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_i (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // remember where new blocks landed so frees can aim at them
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i && issued_q.size() > 0) begin
      done_item = issued_q.pop_front();
      if (out_data_o.status == ST_NEW) begin
        known_off.push_back(out_data_o.address - cur_base);
        known_len.push_back(done_item.req_bytes);
      end
    end
  end

  function automatic in_t mk_req(input logic f, input logic [20:0] r, input logic [31:0] a);
    in_t rq;
    rq.func      = f;
    rq.req_bytes = r;
    rq.addr      = a;
    return rq;
  endfunction

  function automatic in_t random_req();
    in_t         rq;
    int          j;
    int          pick;
    logic [20:0] sz;
    rq.func      = 1'($urandom_range(1));
    rq.req_bytes = 21'($urandom_range(0, 2097151));
    rq.addr      = $urandom();
    pick         = $urandom_range(99);
    if (rq.func == FUNC_ALLOC) begin
      if (pick < 40 && known_len.size() > 0) begin
        // sizes around a known block hit the strictly-larger fit rule
        j  = $urandom_range(known_len.size() - 1);
        sz = known_len[j];
        case ($urandom_range(2))
          0: rq.req_bytes = (sz == 0) ? sz : sz - 21'd1;
          1: rq.req_bytes = sz;
          default: rq.req_bytes = 21'($urandom_range(0, sz));
        endcase
      end else if (pick < 80) begin
        rq.req_bytes = 21'($urandom_range(0, 2048));
      end else if (pick < 92) begin
        rq.req_bytes = 21'($urandom_range(0, 65536));
      end
    end else if (known_off.size() > 0 && pick < 85) begin
      j       = $urandom_range(known_off.size() - 1);
      rq.addr = cur_base + known_off[j];
      // near miss
      if (pick >= 70) rq.addr = rq.addr + 32'($urandom_range(1, 16));
    end
    return rq;
  endfunction

  // called and returns just after a falling edge; valid stays up for a back-to-back transfer
  task automatic send_req(input in_t rq);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= rq;
    do @(posedge clk_i); while (!in_ready_o);
    issued_q.push_back(rq);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] a, input logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (a == REG_HEAP_BASE) cur_base = d;
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    cur_base       = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: zero limit, then a tight limit, then a limit above the cap
    write_reg(REG_HEAP_BASE, DIR_BASE);
    write_reg(REG_HEAP_LIMIT, 32'd0);
    send_req(mk_req(FUNC_ALLOC, 21'd0, 32'd0));          // empty heap, no room
    send_req(mk_req(FUNC_FREE, 21'd0, 32'd0));           // nothing allocated yet
    send_req(mk_req(FUNC_ALLOC, 21'h1F_FFFF, 32'hFFFF_FFFF));
    drain();
    write_reg(REG_HEAP_LIMIT, 32'd40);
    send_req(mk_req(FUNC_ALLOC, 21'd0, 32'd0));          // after the header, address wraps to 0
    send_req(mk_req(FUNC_ALLOC, 21'd12, 32'd0));         // ends exactly at the limit
    send_req(mk_req(FUNC_ALLOC, 21'd1, 32'd0));          // ends past the limit, no room
    send_req(mk_req(FUNC_FREE, 21'h1F_FFFF, DIR_BASE + 32'd16));
    send_req(mk_req(FUNC_ALLOC, 21'd0, 32'd0));          // freed size 0 is not larger than 0
    send_req(mk_req(FUNC_FREE, 21'd0, DIR_BASE + 32'd16)); // freed twice
    drain();
    write_reg(REG_HEAP_LIMIT, 32'h001F_FFFF);
    send_req(mk_req(FUNC_ALLOC, 21'd1048576, 32'd0));
    send_req(mk_req(FUNC_ALLOC, 21'd400000, 32'd0));
    send_req(mk_req(FUNC_ALLOC, 21'd0, 32'd0));
    send_req(mk_req(FUNC_FREE, 21'd0, DIR_BASE + 32'd28));
    send_req(mk_req(FUNC_ALLOC, 21'd12, 32'd0));         // equal size does not fit
    send_req(mk_req(FUNC_ALLOC, 21'd11, 32'd0));         // reuses the 12-byte block
    send_req(mk_req(FUNC_FREE, 21'd0, DIR_BASE + 32'd29));
    send_req(mk_req(FUNC_FREE, 21'd0, DIR_BASE + 32'd400076)); // last block
    send_req(mk_req(FUNC_ALLOC, 21'd0, 32'd0));          // freed last block stays unused
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          phase_base = $urandom();
          phase_limit = LIMIT_CAP;
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          phase_base = 32'hFFFF_FFFF;
          phase_limit = 32'h001F_FFFF;
          send_gap_pct = 52;
          recv_stall_pct = 0;
        end
        2: begin
          phase_base = 32'd0;
          phase_limit = 32'd0;
          send_gap_pct = 0;
          recv_stall_pct = 52;
        end
        3: begin
          phase_base = $urandom();
          phase_limit = $urandom_range(0, LIMIT_CAP);
          send_gap_pct = 20;
          recv_stall_pct = 20;
        end
        default: begin
          phase_base = 32'h8000_0000;
          phase_limit = LIMIT_CAP;
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      write_reg(REG_HEAP_BASE, phase_base);
      write_reg(REG_HEAP_LIMIT, phase_limit);
      repeat (PHASE_ITEMS) send_req(random_req());
      drain();
    end

    repeat (MAX_BLOCKS + 8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("first_fit_heap_allocator regression: pass");
    end else begin
      $display("first_fit_heap_allocator regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("first_fit_heap_allocator regression: fail");
    $finish;
  end

endmodule

>>> first_fit_heap_allocator.f
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_cfg.sv
rtl/ffha_cell.sv
rtl/first_fit_heap_allocator.sv
sim/ffha_checker.sv
sim/tb.sv
